// ===== rtl/pfrt_pkg.sv =====
// Shared constants, types and field layouts for the port filter rule table.
package pfrt_pkg;

  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned POS_W = 5;
  localparam int unsigned RCNT_W = 6;
  localparam int unsigned CMP_W =
    (CNT_W > POS_W) ? ((CNT_W > RCNT_W) ? CNT_W : RCNT_W) :
    ((POS_W > RCNT_W) ? POS_W : RCNT_W);

  localparam int unsigned IN_DATA_W = 128;
  localparam int unsigned OUT_DATA_W = 64;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [31:0] RESET_SERVER_ADDR = 32'hC0A8_3804;
  localparam logic [31:0] RESET_PROXY_ADDR = 32'h8301_0101;

  // functions selected by in_tuser
  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_DEL = 2'd1;
  localparam logic [1:0] FUNC_CLASSIFY = 2'd2;

  // rule kinds
  localparam logic [2:0] KIND_INBOUND = 3'd0;
  localparam logic [2:0] KIND_OUTBOUND = 3'd1;
  localparam logic [2:0] KIND_FORWARD = 3'd2;
  localparam logic [2:0] KIND_PROXY = 3'd3;
  localparam logic [2:0] KIND_INVALID = 3'd4;

  // hook points
  localparam logic [1:0] HOOK_INBOUND = 2'd0;
  localparam logic [1:0] HOOK_OUTBOUND = 2'd1;
  localparam logic [1:0] HOOK_FORWARD = 2'd2;
  localparam logic [1:0] HOOK_PROXY = 2'd3;

  // status codes
  localparam logic [1:0] STAT_OK = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_BAD_POS = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_ADDR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROXY_ADDR = 1'd1;

  // table edit broadcast to every cell
  typedef struct packed {
    logic             add_en;
    logic             del_en;
    logic [2:0]       kind;
    logic [15:0]      port;
    logic [POS_W-1:0] del_pos;
    logic [CNT_W-1:0] cnt;
  } edit_t;

  // search word handed from cell to cell
  typedef struct packed {
    logic        vld;
    logic [2:0]  kind;
    logic [15:0] port;
    logic        hit;
  } srch_t;

endpackage

// ===== rtl/pfrt_cell.sv =====
// One rule cell: holds a rule, takes edits, and passes the search word on.
module pfrt_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [pfrt_pkg::CNT_W-1:0] cell_idx,
  input  pfrt_pkg::edit_t       edit,
  input  logic [2:0]            nb_kind,
  input  logic [15:0]           nb_port,
  output logic [2:0]            kind_q,
  output logic [15:0]           port_q,
  input  pfrt_pkg::srch_t       srch_i,
  output pfrt_pkg::srch_t       srch_o
);
  import pfrt_pkg::*;

  logic [2:0]  kind_r;
  logic [15:0] port_r;
  srch_t       srch_r;
  srch_t       srch_nxt;
  logic        occ;
  logic        wr_sel;
  logic        shift_sel;
  logic        match;

  assign occ = CMP_W'(cell_idx) < CMP_W'(edit.cnt);
  assign wr_sel = edit.add_en && (cell_idx == edit.cnt);
  // delete: occupied cells at and above the removed position take the next cell's rule
  assign shift_sel = edit.del_en && occ && (CMP_W'(cell_idx) >= CMP_W'(edit.del_pos));
  assign match = occ && (srch_i.kind == kind_r) && (srch_i.port == port_r);

  always_ff @(posedge clk) begin
    if (wr_sel) begin
      kind_r <= edit.kind;
      port_r <= edit.port;
    end else if (shift_sel) begin
      kind_r <= nb_kind;
      port_r <= nb_port;
    end
  end

  always_comb begin
    srch_nxt = srch_i;
    srch_nxt.hit = srch_i.hit | (srch_i.vld & match);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srch_r <= '0;
    end else begin
      srch_r <= srch_nxt;
    end
  end

  assign kind_q = kind_r;
  assign port_q = port_r;
  assign srch_o = srch_r;

endmodule

// ===== rtl/port_filter_rule_table_unit.sv =====
// Top level of the port filter rule table: control, config and the cell row.
// Usage: each in_ word carries one command, chosen by in_tuser: add a rule,
// delete the rule at a position (oldest first), or classify a packet header.
// Every command yields exactly one out_ word with status, drop and rewrite
// flags, the destination after classification and the rule count.
// cfg_ writes set the server and proxy addresses; cfg_ready is always high,
// and writes are meant for when no command is in flight.
// One command at a time. Add, delete and the unused function pass from the
// result register into the output register; classify first waits for the
// search word to walk the row of rule cells, one cell per cycle. The next
// command is taken once the result has moved into the output register.
// Reset empties the table and restores both addresses. When out_tready is
// low the result holds in the output register and one more finished result
// waits behind it; in_tready stays low until it moves on.
module port_filter_rule_table_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  // rule_kind[2:0] rule_port[18:3] del_position[23:19] hook_point[25:24]
  // src_addr[57:26] dst_addr[89:58] src_port[105:90] dst_port[121:106]
  input  logic [pfrt_pkg::IN_DATA_W-1:0]  in_tdata,
  // func[1:0]
  input  logic [1:0]                      in_tuser,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // status[1:0] drop[2] rewritten[3] out_dst_addr[35:4] out_dst_port[51:36]
  // rule_count[57:52]
  output logic [pfrt_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pfrt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_data
);
  import pfrt_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SRCH = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  typedef struct packed {
    logic [RCNT_W-1:0] rule_count;
    logic [15:0]       dst_port;
    logic [31:0]       dst_addr;
    logic              rewritten;
    logic              drop;
    logic [1:0]        status;
  } res_t;

  // input fields
  logic [1:0]       f_func;
  logic [2:0]       f_kind;
  logic [15:0]      f_rport;
  logic [POS_W-1:0] f_dpos;
  logic [1:0]       f_hook;
  logic [31:0]      f_saddr;
  logic [31:0]      f_daddr;
  logic [15:0]      f_sport;
  logic [15:0]      f_dport;

  assign f_kind = in_tdata[2:0];
  assign f_rport = in_tdata[18:3];
  assign f_dpos = in_tdata[23:19];
  assign f_hook = in_tdata[25:24];
  assign f_saddr = in_tdata[57:26];
  assign f_daddr = in_tdata[89:58];
  assign f_sport = in_tdata[105:90];
  assign f_dport = in_tdata[121:106];
  assign f_func = in_tuser;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      srv_r, prx_r;
  logic             gate_r;
  logic             proxy_r;
  logic [31:0]      daddr_r;
  logic [15:0]      dport_r;
  logic [15:0]      sport_r;
  res_t             res_r, res_nxt;
  res_t             out_r;
  logic             out_vld_r;

  logic       acc;
  logic       full;
  logic       del_ok;
  logic       out_free;
  logic       hit;
  edit_t      edit;
  srch_t      launch;
  logic [2:0] key_kind;
  logic [15:0] key_port;
  logic       gate;

  srch_t       srch_w [TABLE_DEPTH+1];
  logic [2:0]  kind_w [TABLE_DEPTH];
  logic [15:0] port_w [TABLE_DEPTH];

  assign in_tready = (state_r == ST_IDLE);
  assign acc = in_tvalid && in_tready;
  assign full = CMP_W'(cnt_r) >= CMP_W'(TABLE_DEPTH);
  assign del_ok = CMP_W'(f_dpos) < CMP_W'(cnt_r);
  assign out_free = !out_vld_r || out_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    edit.add_en = acc && (f_func == FUNC_ADD) && !full;
    edit.del_en = acc && (f_func == FUNC_DEL) && del_ok;
    edit.kind = (f_kind > KIND_INVALID) ? KIND_INVALID : f_kind;
    edit.port = f_rport;
    edit.del_pos = f_dpos;
    edit.cnt = cnt_r;
  end

  // search key and address gate from the hook point
  always_comb begin
    unique case (f_hook)
      HOOK_INBOUND: begin
        key_kind = KIND_INBOUND;
        key_port = f_sport;
        gate = (f_saddr == srv_r);
      end
      HOOK_OUTBOUND: begin
        key_kind = KIND_OUTBOUND;
        key_port = f_dport;
        gate = (f_saddr == srv_r) || (f_daddr == srv_r);
      end
      HOOK_FORWARD: begin
        key_kind = KIND_FORWARD;
        key_port = f_sport;
        gate = (f_saddr == srv_r);
      end
      HOOK_PROXY: begin
        key_kind = KIND_PROXY;
        key_port = f_sport;
        gate = (f_saddr == srv_r);
      end
      default: begin
        key_kind = KIND_INVALID;
        key_port = f_sport;
        gate = 1'b0;
      end
    endcase
  end

  always_comb begin
    launch.vld = acc && (f_func == FUNC_CLASSIFY);
    launch.kind = key_kind;
    launch.port = key_port;
    launch.hit = 1'b0;
  end

  assign srch_w[0] = launch;

  // row of rule cells; cell i holds the rule at position i, oldest first
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [2:0]  nb_kind;
    logic [15:0] nb_port;
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign nb_kind = kind_w[i];
      assign nb_port = port_w[i];
    end else begin : g_mid
      assign nb_kind = kind_w[i+1];
      assign nb_port = port_w[i+1];
    end
    pfrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (CNT_W'(i)),
      .edit     (edit),
      .nb_kind  (nb_kind),
      .nb_port  (nb_port),
      .kind_q   (kind_w[i]),
      .port_q   (port_w[i]),
      .srch_i   (srch_w[i]),
      .srch_o   (srch_w[i+1])
    );
  end

  assign hit = srch_w[TABLE_DEPTH].hit && gate_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (edit.add_en) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (edit.del_en) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    res_nxt = res_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          res_nxt = '0;
          res_nxt.rule_count = RCNT_W'(CMP_W'(cnt_nxt));
          case (f_func)
            FUNC_ADD: res_nxt.status = full ? STAT_FULL : STAT_OK;
            FUNC_DEL: res_nxt.status = del_ok ? STAT_OK : STAT_BAD_POS;
            default: res_nxt.status = STAT_OK;
          endcase
          state_nxt = (f_func == FUNC_CLASSIFY) ? ST_SRCH : ST_DONE;
        end
      end
      ST_SRCH: begin
        if (srch_w[TABLE_DEPTH].vld) begin
          res_nxt.status = STAT_OK;
          res_nxt.drop = hit && !proxy_r;
          res_nxt.rewritten = hit && proxy_r;
          res_nxt.dst_addr = (hit && proxy_r) ? prx_r : daddr_r;
          res_nxt.dst_port = (hit && proxy_r) ? sport_r : dport_r;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      srv_r <= RESET_SERVER_ADDR;
      prx_r <= RESET_PROXY_ADDR;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_SERVER_ADDR: srv_r <= cfg_data;
          CFG_PROXY_ADDR: prx_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == ST_DONE && out_free) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // result register, packet context kept while the search word walks the row, and the output register
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (acc) begin
      gate_r <= gate;
      proxy_r <= (f_hook == HOOK_PROXY);
      daddr_r <= f_daddr;
      dport_r <= f_dport;
      sport_r <= f_sport;
    end
    if (state_r == ST_DONE && out_free) begin
      out_r <= res_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata = OUT_DATA_W'(out_r);

endmodule

// ===== bench/tb_port_filter_rule_table_unit.sv =====
// Self-checking testbench for the port filter rule table: directed, random and stall phases.
`timescale 1ns / 100ps

module tb_port_filter_rule_table_unit;
  import pfrt_pkg::*;

  localparam logic [1:0]  FUNC_UNUSED  = 2'd3;
  localparam logic [2:0]  KIND_UNKNOWN = 3'd7;
  localparam logic [31:0] OTHER_ADDR   = 32'h0A00_0001;
  localparam int          WD_LIMIT     = 2000;
  localparam int          LONG_HOLD    = 400;
  localparam int          TAIL_CYCLES  = TABLE_DEPTH + 8;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  kind;
    logic [15:0] rport;
    logic [4:0]  dpos;
    logic [1:0]  hook;
    logic [31:0] saddr;
    logic [31:0] daddr;
    logic [15:0] sport;
    logic [15:0] dport;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        drop;
    logic        rewritten;
    logic [31:0] dst_addr;
    logic [15:0] dst_port;
    logic [5:0]  count;
  } verdict_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]            in_tuser = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [31:0]           cfg_data = '0;

  port_filter_rule_table_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // shadow of the rule ring and the address registers
  logic [2:0]  kind_tbl [TABLE_DEPTH];
  logic [15:0] port_tbl [TABLE_DEPTH];
  int          head_ix = 0;
  int          tail_ix = TABLE_DEPTH - 1;
  int          live_rules = 0;
  logic [31:0] server_reg = RESET_SERVER_ADDR;
  logic [31:0] proxy_reg = RESET_PROXY_ADDR;

  cmd_t     cmd_q[$];
  verdict_t verdict_q[$];
  cmd_t     cur_cmd;
  int       gen_cnt = 0;
  logic [15:0] port_pool [8];

  logic tx_idle_on = 1'b0;
  logic rx_idle_on = 1'b0;
  logic hold_rx = 1'b0;
  int   gap_left = 0;
  int   rx_wait = 0;
  int   idle_cycles = 0;

  int err_cnt = 0, n_words = 0, n_cfg = 0;
  int n_add = 0, n_full = 0, n_del = 0, n_badpos = 0;
  int n_cls = 0, n_drop = 0, n_rew = 0, n_unused = 0;

  function automatic logic rule_hit(logic [2:0] kind, logic [15:0] port);
    int pos;
    pos = head_ix;
    for (int n = 0; n < live_rules; n++) begin
      if (kind_tbl[pos] == kind && port_tbl[pos] == port) return 1'b1;
      pos = (pos + 1) % TABLE_DEPTH;
    end
    return 1'b0;
  endfunction

  function automatic verdict_t predict_verdict(cmd_t c);
    verdict_t v;
    int pos, prv;
    v = '0;
    case (c.func)
      FUNC_ADD: begin
        n_add++;
        if (live_rules >= TABLE_DEPTH) begin
          v.status = STAT_FULL;
          n_full++;
        end else begin
          tail_ix = (tail_ix + 1) % TABLE_DEPTH;
          kind_tbl[tail_ix] = (c.kind > KIND_INVALID) ? KIND_INVALID : c.kind;
          port_tbl[tail_ix] = c.rport;
          live_rules++;
        end
      end
      FUNC_DEL: begin
        n_del++;
        if (c.dpos >= live_rules) begin
          v.status = STAT_BAD_POS;
          n_badpos++;
        end else begin
          // slide older rules up over the victim, then retire the head slot
          pos = (head_ix + c.dpos) % TABLE_DEPTH;
          while (pos != head_ix) begin
            prv = (pos == 0) ? TABLE_DEPTH - 1 : pos - 1;
            kind_tbl[pos] = kind_tbl[prv];
            port_tbl[pos] = port_tbl[prv];
            pos = prv;
          end
          head_ix = (head_ix + 1) % TABLE_DEPTH;
          live_rules--;
        end
      end
      FUNC_CLASSIFY: begin
        n_cls++;
        v.dst_addr = c.daddr;
        v.dst_port = c.dport;
        case (c.hook)
          HOOK_INBOUND:
            v.drop = (c.saddr == server_reg) && rule_hit(KIND_INBOUND, c.sport);
          HOOK_OUTBOUND:
            v.drop = (c.saddr == server_reg || c.daddr == server_reg) &&
                     rule_hit(KIND_OUTBOUND, c.dport);
          HOOK_FORWARD:
            v.drop = (c.saddr == server_reg) && rule_hit(KIND_FORWARD, c.sport);
          default: begin
            if (c.saddr == server_reg && rule_hit(KIND_PROXY, c.sport)) begin
              v.rewritten = 1'b1;
              v.dst_addr = proxy_reg;
              v.dst_port = c.sport;
            end
          end
        endcase
        n_drop += v.drop;
        n_rew += v.rewritten;
      end
      default: n_unused++;
    endcase
    v.count = live_rules[5:0];
    return v;
  endfunction

  function automatic logic [15:0] pick_port();
    return ($urandom_range(0, 9) < 7) ? port_pool[$urandom_range(0, 7)]
                                      : 16'($urandom_range(0, 65535));
  endfunction

  function automatic cmd_t rand_cmd(int add_w, int del_w);
    cmd_t c;
    int r;
    r = $urandom_range(0, 99);
    if (r < add_w) c.func = FUNC_ADD;
    else if (r < add_w + del_w) c.func = FUNC_DEL;
    else if (r < 97) c.func = FUNC_CLASSIFY;
    else c.func = FUNC_UNUSED;
    c.kind = 3'($urandom_range(0, 7));
    c.rport = pick_port();
    if (gen_cnt > 0 && $urandom_range(0, 4) != 0) c.dpos = 5'($urandom_range(0, gen_cnt - 1));
    else c.dpos = 5'($urandom_range(0, 31));
    c.hook = 2'($urandom_range(0, 3));
    c.saddr = ($urandom_range(0, 9) < 7) ? server_reg : $urandom;
    c.daddr = ($urandom_range(0, 9) < 3) ? server_reg : $urandom;
    c.sport = pick_port();
    c.dport = pick_port();
    return c;
  endfunction

  // keeps a running rule count so deletes can aim at live positions
  task automatic queue_cmd(cmd_t c);
    if (c.func == FUNC_ADD && gen_cnt < TABLE_DEPTH) gen_cnt++;
    if (c.func == FUNC_DEL && c.dpos < gen_cnt) gen_cnt--;
    cmd_q.push_back(c);
  endtask

  task automatic add_rule(logic [2:0] kind, logic [15:0] port);
    cmd_t c;
    c = '0;
    c.func = FUNC_ADD;
    c.kind = kind;
    c.rport = port;
    queue_cmd(c);
  endtask

  task automatic del_rule(logic [4:0] pos);
    cmd_t c;
    c = '0;
    c.func = FUNC_DEL;
    c.dpos = pos;
    queue_cmd(c);
  endtask

  task automatic classify(logic [1:0] hook, logic [31:0] sa, logic [31:0] da,
                          logic [15:0] sp, logic [15:0] dp);
    cmd_t c;
    c = '0;
    c.func = FUNC_CLASSIFY;
    c.hook = hook;
    c.saddr = sa;
    c.daddr = da;
    c.sport = sp;
    c.dport = dp;
    queue_cmd(c);
  endtask

  task automatic run_random(int n, int add_w, int del_w, logic tx_idle, logic rx_idle);
    @(negedge clk);
    tx_idle_on = tx_idle;
    rx_idle_on = rx_idle;
    port_pool[0] = 16'h0000;
    port_pool[1] = 16'hFFFF;
    for (int i = 2; i < 8; i++) port_pool[i] = 16'($urandom_range(0, 65535));
    repeat (n) queue_cmd(rand_cmd(add_w, del_w));
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (cmd_q.size() != 0 || verdict_q.size() != 0 || in_tvalid);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_SERVER_ADDR) server_reg = val;
    else proxy_reg = val;
    n_cfg++;
  endtask

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    err_cnt++;
    if (err_cnt <= 40)
      $display("%0t ns word %0d: %s expected %0h got %0h", $time, n_words, what, want, got);
  endtask

  // command driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        verdict_q.push_back(predict_verdict(cur_cmd));
        gap_left = tx_idle_on ? $urandom_range(0, 11) : 0;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          cur_cmd = cmd_q.pop_front();
          in_tdata <= {6'b0, cur_cmd.dport, cur_cmd.sport, cur_cmd.daddr, cur_cmd.saddr,
                       cur_cmd.hook, cur_cmd.dpos, cur_cmd.rport, cur_cmd.kind};
          in_tuser <= cur_cmd.func;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver backpressure
  always @(posedge clk) begin
    verdict_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.status = out_tdata[1:0];
        got.drop = out_tdata[2];
        got.rewritten = out_tdata[3];
        got.dst_addr = out_tdata[35:4];
        got.dst_port = out_tdata[51:36];
        got.count = out_tdata[57:52];
        if (verdict_q.size() == 0) begin
          report_mismatch("word with no command pending", '0, out_tdata);
        end else begin
          want = verdict_q.pop_front();
          if (got.status !== want.status) report_mismatch("status", want.status, got.status);
          if (got.drop !== want.drop) report_mismatch("drop", want.drop, got.drop);
          if (got.rewritten !== want.rewritten)
            report_mismatch("rewritten", want.rewritten, got.rewritten);
          if (got.dst_addr !== want.dst_addr)
            report_mismatch("dst_addr", want.dst_addr, got.dst_addr);
          if (got.dst_port !== want.dst_port)
            report_mismatch("dst_port", want.dst_port, got.dst_port);
          if (got.count !== want.count) report_mismatch("rule_count", want.count, got.count);
        end
        n_words++;
        rx_wait = rx_idle_on ? $urandom_range(0, 11) : 0;
      end
      if (hold_rx) begin
        out_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WD_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", WD_LIMIT);
        $display("** port_filter_rule_table_unit: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: one rule of each kind, every hook, hit and miss, invalid and
    // unknown kinds, the unused function and in-range and bad deletes
    add_rule(KIND_INBOUND, 16'h0000);
    add_rule(KIND_OUTBOUND, 16'hFFFF);
    add_rule(KIND_FORWARD, 16'd80);
    add_rule(KIND_PROXY, 16'd8080);
    add_rule(KIND_INVALID, 16'd1234);
    add_rule(KIND_UNKNOWN, 16'd4321);
    classify(HOOK_INBOUND, server_reg, OTHER_ADDR, 16'h0000, 16'h1111);
    classify(HOOK_INBOUND, server_reg, OTHER_ADDR, 16'h0001, 16'h1111);
    classify(HOOK_OUTBOUND, OTHER_ADDR, server_reg, 16'd7, 16'hFFFF);
    classify(HOOK_OUTBOUND, server_reg, 32'hFFFF_FFFF, 16'd7, 16'hFFFF);
    classify(HOOK_OUTBOUND, OTHER_ADDR, OTHER_ADDR, 16'd7, 16'hFFFF);
    classify(HOOK_FORWARD, server_reg, 32'h0, 16'd80, 16'h0);
    classify(HOOK_FORWARD, OTHER_ADDR, 32'h0, 16'd80, 16'h0);
    classify(HOOK_PROXY, server_reg, 32'hFFFF_FFFF, 16'd8080, 16'hFFFF);
    classify(HOOK_PROXY, server_reg, 32'h0, 16'd1234, 16'd5);
    classify(HOOK_INBOUND, server_reg, 32'h0, 16'd4321, 16'd5);
    classify(HOOK_INBOUND, server_reg, 32'h0, 16'd80, 16'd5);
    begin
      cmd_t c;
      c = rand_cmd(0, 0);
      c.func = FUNC_UNUSED;
      queue_cmd(c);
    end
    del_rule(5'd0);
    del_rule(5'd2);
    del_rule(5'd31);
    del_rule(5'd4);
    classify(HOOK_PROXY, server_reg, 32'h0, 16'd8080, 16'h0);
    wait_drained();

    // extreme addresses, add-heavy so the ring fills and reports full
    write_reg(CFG_SERVER_ADDR, 32'h0000_0000);
    write_reg(CFG_PROXY_ADDR, 32'hFFFF_FFFF);
    run_random(250, 60, 10, 1'b1, 1'b1);
    wait_drained();

    // receiver stalls for a long stretch while commands keep coming
    fork
      begin
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_rx <= 1'b0;
      end
    join_none
    run_random(80, 30, 20, 1'b0, 1'b0);
    wait_drained();

    write_reg(CFG_SERVER_ADDR, 32'hFFFF_FFFF);
    write_reg(CFG_PROXY_ADDR, 32'h0000_0000);
    run_random(300, 25, 25, 1'b0, 1'b0);
    wait_drained();

    // delete-heavy: drains the ring, bad positions on an empty table
    write_reg(CFG_SERVER_ADDR, $urandom);
    write_reg(CFG_PROXY_ADDR, $urandom);
    run_random(300, 15, 45, 1'b1, 1'b1);
    wait_drained();

    write_reg(CFG_PROXY_ADDR, RESET_PROXY_ADDR);
    write_reg(CFG_SERVER_ADDR, RESET_SERVER_ADDR);
    run_random(300, 35, 20, 1'b1, 1'b0);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run: %0d words checked, %0d register writes, %0d adds (%0d full), %0d deletes",
             n_words, n_cfg, n_add, n_full, n_del);
    $display("     %0d bad positions, %0d classifies (%0d dropped, %0d redirected), %0d unused",
             n_badpos, n_cls, n_drop, n_rew, n_unused);
    if (err_cnt == 0) begin
      $display("** port_filter_rule_table_unit: PASSED **");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("** port_filter_rule_table_unit: FAILED **");
    end
    $finish;
  end

endmodule
